@@ rtl/hsbt_pkg.sv @@
// Shared widths, register codes, reset values and the sweep token type for the boundary tracker.
`timescale 1ns / 1ps

package hsbt_pkg;

   localparam int TS_W      = 64;
   localparam int REG_W     = 40;
   localparam int SEQ_W     = 32;
   localparam int PART_W    = 16;
   localparam int MASK_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SEG_CLOSE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PART_MIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PURGE_AGE = 2'd2;

   localparam logic [REG_W-1:0] SEG_CLOSE_RESET = 40'd1500000000;
   localparam logic [REG_W-1:0] PART_MIN_RESET  = 40'd200000000;
   localparam logic [REG_W-1:0] PURGE_AGE_RESET = 40'd6000000000;

   localparam logic [PART_W-1:0] PART_MAX = 16'hFFFF;

   typedef struct packed {
      logic            go;
      logic [TS_W-1:0] pts;
   } tok_type;

endpackage

@@ rtl/hsbt_cell.sv @@
// One window slot: holds a segment start time and tests the passing sweep token against purge age.
`timescale 1ns / 1ps

module hsbt_cell
   import hsbt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [TS_W-1:0]  wr_data,
   input  logic             slot_filled,
   input  logic [REG_W-1:0] purge_age,
   input  tok_type          tok_prev,
   output tok_type          tok_next,
   output logic             hit
);

   logic [TS_W-1:0] start_ff, start_in;
   logic            go_ff, go_in;
   logic [TS_W-1:0] pts_ff, pts_in;
   logic            hit_ff, hit_in;
   logic [TS_W-1:0] age;

   assign age = tok_prev.pts - start_ff;

   always_comb begin
      start_in = wr_en ? wr_data : start_ff;
      go_in    = tok_prev.go;
      pts_in   = tok_prev.pts;
      hit_in   = hit_ff;
      if (tok_prev.go) begin
         hit_in = slot_filled && (age > {{(TS_W-REG_W){1'b0}}, purge_age});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
      end
      start_ff <= start_in;
      pts_ff   <= pts_in;
      hit_ff   <= hit_in;
   end

   assign tok_next.go  = go_ff;
   assign tok_next.pts = pts_ff;
   assign hit          = hit_ff;

endmodule

@@ rtl/hls_segment_boundary_tracker.sv @@
// Top level of the segment and part boundary tracker.
//
// Requests arrive on req_ (timestamp, timestamp valid, keyframe flag); each
// request gives exactly one response on rsp_ with segment and part numbers,
// boundary flags, closed durations and the purge mask of the window.
// Registers are written through csr_ (index, 40-bit data) while idle; the
// user must keep to this, the block does not enforce it. csr_ready is always
// high and unknown indexes are ignored. A request passes the diff, eval,
// sweep and done states; one request is in work at a time, so the next is
// taken only after the done state. Most of the work is the sweep token that
// walks the row of window cells, one cell per cycle, to test purge age.
// A finished response sits in the output register while the next request is
// taken and worked; if the receiver still stalls when that one completes,
// the block holds it until the register frees.
// Reset (synchronous) empties the window, clears sequence and part state,
// sets the last timestamp to all ones and loads register defaults.
`timescale 1ns / 1ps

module hls_segment_boundary_tracker
   import hsbt_pkg::*;
#(
   parameter int WINDOW_SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TS_W-1:0]      req_timestamp_ns,
   input  logic                 req_timestamp_valid,
   input  logic                 req_is_keyframe,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SEQ_W-1:0]     rsp_segment_number,
   output logic [PART_W-1:0]    rsp_part_number,
   output logic                 rsp_starts_segment,
   output logic                 rsp_starts_part,
   output logic                 rsp_part_independent,
   output logic                 rsp_segment_closed,
   output logic [TS_W-1:0]      rsp_segment_length_ns,
   output logic                 rsp_part_closed,
   output logic [TS_W-1:0]      rsp_part_length_ns,
   output logic [MASK_W-1:0]    rsp_purge_mask,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int FILL_W = $clog2(WINDOW_SLOTS + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIFF  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [REG_W-1:0]  seg_close_ff, seg_close_in;
   logic [REG_W-1:0]  part_min_ff, part_min_in;
   logic [REG_W-1:0]  purge_age_ff, purge_age_in;
   logic [TS_W-1:0]   last_ts_ff, last_ts_in;
   logic [SEQ_W-1:0]  next_seq_ff, next_seq_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [TS_W-1:0]   seg_start_ff, seg_start_in;
   logic [TS_W-1:0]   part_start_ff, part_start_in;
   logic [PART_W-1:0] part_idx_ff, part_idx_in;
   logic              part_open_ff, part_open_in;

   logic [TS_W-1:0]   pts_ff, pts_in;
   logic              key_ff, key_in;
   logic [TS_W-1:0]   seg_diff_ff, seg_diff_in;
   logic [TS_W-1:0]   part_diff_ff, part_diff_in;
   logic              tok_go_ff, tok_go_in;

   logic [SEQ_W-1:0]  st_seg_num_ff, st_seg_num_in;
   logic [PART_W-1:0] st_part_num_ff, st_part_num_in;
   logic              st_new_seg_ff, st_new_seg_in;
   logic              st_new_part_ff, st_new_part_in;
   logic              st_seg_closed_ff, st_seg_closed_in;
   logic              st_prt_closed_ff, st_prt_closed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]  rsp_seg_num_ff, rsp_seg_num_in;
   logic [PART_W-1:0] rsp_part_num_ff, rsp_part_num_in;
   logic              rsp_new_seg_ff, rsp_new_seg_in;
   logic              rsp_new_part_ff, rsp_new_part_in;
   logic              rsp_indep_ff, rsp_indep_in;
   logic              rsp_seg_closed_ff, rsp_seg_closed_in;
   logic [TS_W-1:0]   rsp_seg_len_ff, rsp_seg_len_in;
   logic              rsp_prt_closed_ff, rsp_prt_closed_in;
   logic [TS_W-1:0]   rsp_prt_len_ff, rsp_prt_len_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;

   logic                    win_wr;
   logic [SLOT_W-1:0]       win_slot;
   logic [WINDOW_SLOTS-1:0] cell_wr;
   logic [WINDOW_SLOTS-1:0] cell_filled;
   logic [WINDOW_SLOTS-1:0] cell_hit;
   tok_type                 chain [WINDOW_SLOTS+1];
   logic [MASK_W-1:0]       mask_w;
   logic                    full;
   logic                    seg_due;
   logic                    part_due;
   logic                    new_seg;

   assign full     = (fill_ff == FILL_FULL);
   assign seg_due  = key_ff && (seg_diff_ff > {{(TS_W-REG_W){1'b0}}, seg_close_ff});
   assign part_due = !(part_diff_ff < {{(TS_W-REG_W){1'b0}}, part_min_ff});
   assign new_seg  = (fill_ff == '0) || seg_due;
   assign win_slot = full ? head_ff : fill_ff[SLOT_W-1:0];
   assign win_wr   = (state_ff == ST_EVAL) && new_seg;

   assign chain[0].go  = tok_go_ff;
   assign chain[0].pts = pts_ff;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_SLOTS; gi++) begin : g_cell
         assign cell_wr[gi]     = win_wr && (win_slot == SLOT_W'(gi));
         assign cell_filled[gi] = (fill_ff > FILL_W'(gi));
         hsbt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .wr_en       (cell_wr[gi]),
            .wr_data     (pts_ff),
            .slot_filled (cell_filled[gi]),
            .purge_age   (purge_age_ff),
            .tok_prev    (chain[gi]),
            .tok_next    (chain[gi+1]),
            .hit         (cell_hit[gi])
         );
      end
      for (gi = 0; gi < MASK_W; gi++) begin : g_mask
         if (gi < WINDOW_SLOTS) begin : g_used
            assign mask_w[gi] = cell_hit[gi];
         end else begin : g_unused
            assign mask_w[gi] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      state_in          = state_ff;
      seg_close_in      = seg_close_ff;
      part_min_in       = part_min_ff;
      purge_age_in      = purge_age_ff;
      last_ts_in        = last_ts_ff;
      next_seq_in       = next_seq_ff;
      fill_in           = fill_ff;
      head_in           = head_ff;
      newest_in         = newest_ff;
      seg_start_in      = seg_start_ff;
      part_start_in     = part_start_ff;
      part_idx_in       = part_idx_ff;
      part_open_in      = part_open_ff;
      pts_in            = pts_ff;
      key_in            = key_ff;
      seg_diff_in       = seg_diff_ff;
      part_diff_in      = part_diff_ff;
      tok_go_in         = 1'b0;
      st_seg_num_in     = st_seg_num_ff;
      st_part_num_in    = st_part_num_ff;
      st_new_seg_in     = st_new_seg_ff;
      st_new_part_in    = st_new_part_ff;
      st_seg_closed_in  = st_seg_closed_ff;
      st_prt_closed_in  = st_prt_closed_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_seg_num_in    = rsp_seg_num_ff;
      rsp_part_num_in   = rsp_part_num_ff;
      rsp_new_seg_in    = rsp_new_seg_ff;
      rsp_new_part_in   = rsp_new_part_ff;
      rsp_indep_in      = rsp_indep_ff;
      rsp_seg_closed_in = rsp_seg_closed_ff;
      rsp_seg_len_in    = rsp_seg_len_ff;
      rsp_prt_closed_in = rsp_prt_closed_ff;
      rsp_prt_len_in    = rsp_prt_len_ff;
      rsp_mask_in       = rsp_mask_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_SEG_CLOSE: seg_close_in = csr_data;
            REG_PART_MIN:  part_min_in  = csr_data;
            REG_PURGE_AGE: purge_age_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = req_is_keyframe;
               if (req_timestamp_valid) begin
                  pts_in     = req_timestamp_ns;
                  last_ts_in = req_timestamp_ns;
               end else begin
                  pts_in = last_ts_ff;
               end
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            seg_diff_in  = pts_ff - seg_start_ff;
            part_diff_in = pts_ff - part_start_ff;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            st_new_seg_in    = new_seg;
            st_seg_closed_in = (fill_ff != '0) && seg_due;
            st_prt_closed_in = 1'b0;
            st_new_part_in   = 1'b1;
            if (new_seg) begin
               st_prt_closed_in = (fill_ff != '0) && part_open_ff;
               if (full) begin
                  head_in = (head_ff == SLOT_LAST) ? '0 : head_ff + 1'b1;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
               newest_in     = win_slot;
               seg_start_in  = pts_ff;
               st_seg_num_in = next_seq_ff;
               next_seq_in   = next_seq_ff + 1'b1;
               part_idx_in   = '0;
               part_start_in = pts_ff;
               part_open_in  = 1'b1;
            end else begin
               st_seg_num_in = next_seq_ff - 1'b1;
               if (!part_open_ff) begin
                  part_start_in = pts_ff;
                  part_open_in  = 1'b1;
                  if (part_idx_ff != PART_MAX) begin
                     part_idx_in = part_idx_ff + 1'b1;
                  end
               end else if (part_due) begin
                  st_prt_closed_in = 1'b1;
                  part_start_in    = pts_ff;
                  if (part_idx_ff != PART_MAX) begin
                     part_idx_in = part_idx_ff + 1'b1;
                  end
               end else begin
                  st_new_part_in = 1'b0;
               end
            end
            st_part_num_in = part_idx_in;
            tok_go_in      = 1'b1;
            state_in       = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (chain[WINDOW_SLOTS].go) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (mask_w[newest_ff]) begin
                  part_open_in = 1'b0;
               end
               rsp_valid_in      = 1'b1;
               rsp_seg_num_in    = st_seg_num_ff;
               rsp_part_num_in   = st_part_num_ff;
               rsp_new_seg_in    = st_new_seg_ff;
               rsp_new_part_in   = st_new_part_ff;
               rsp_indep_in      = st_new_part_ff && key_ff;
               rsp_seg_closed_in = st_seg_closed_ff;
               rsp_seg_len_in    = st_seg_closed_ff ? seg_diff_ff : '0;
               rsp_prt_closed_in = st_prt_closed_ff;
               rsp_prt_len_in    = st_prt_closed_ff ? part_diff_ff : '0;
               rsp_mask_in       = mask_w;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_close_ff <= SEG_CLOSE_RESET;
         part_min_ff  <= PART_MIN_RESET;
         purge_age_ff <= PURGE_AGE_RESET;
         last_ts_ff   <= '1;
         next_seq_ff  <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         newest_ff    <= '0;
         seg_start_ff <= '0;
         part_start_ff <= '0;
         part_idx_ff  <= '0;
         part_open_ff <= 1'b0;
         tok_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_close_ff <= seg_close_in;
         part_min_ff  <= part_min_in;
         purge_age_ff <= purge_age_in;
         last_ts_ff   <= last_ts_in;
         next_seq_ff  <= next_seq_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         newest_ff    <= newest_in;
         seg_start_ff <= seg_start_in;
         part_start_ff <= part_start_in;
         part_idx_ff  <= part_idx_in;
         part_open_ff <= part_open_in;
         tok_go_ff    <= tok_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pts_ff            <= pts_in;
      key_ff            <= key_in;
      seg_diff_ff       <= seg_diff_in;
      part_diff_ff      <= part_diff_in;
      st_seg_num_ff     <= st_seg_num_in;
      st_part_num_ff    <= st_part_num_in;
      st_new_seg_ff     <= st_new_seg_in;
      st_new_part_ff    <= st_new_part_in;
      st_seg_closed_ff  <= st_seg_closed_in;
      st_prt_closed_ff  <= st_prt_closed_in;
      rsp_seg_num_ff    <= rsp_seg_num_in;
      rsp_part_num_ff   <= rsp_part_num_in;
      rsp_new_seg_ff    <= rsp_new_seg_in;
      rsp_new_part_ff   <= rsp_new_part_in;
      rsp_indep_ff      <= rsp_indep_in;
      rsp_seg_closed_ff <= rsp_seg_closed_in;
      rsp_seg_len_ff    <= rsp_seg_len_in;
      rsp_prt_closed_ff <= rsp_prt_closed_in;
      rsp_prt_len_ff    <= rsp_prt_len_in;
      rsp_mask_ff       <= rsp_mask_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_segment_number    = rsp_seg_num_ff;
   assign rsp_part_number       = rsp_part_num_ff;
   assign rsp_starts_segment    = rsp_new_seg_ff;
   assign rsp_starts_part       = rsp_new_part_ff;
   assign rsp_part_independent  = rsp_indep_ff;
   assign rsp_segment_closed    = rsp_seg_closed_ff;
   assign rsp_segment_length_ns = rsp_seg_len_ff;
   assign rsp_part_closed       = rsp_prt_closed_ff;
   assign rsp_part_length_ns    = rsp_prt_len_ff;
   assign rsp_purge_mask        = rsp_mask_ff;

endmodule
